/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset disable, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* rtl/owm_pkg.sv */
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int CFG_W   = 10;
  localparam int CFG_NUM = 8;
  localparam int CFG_IW  = 3;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_RESET_LOW   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PRES_SAMPLE = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_RESET_REL   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WR1_LOW     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_WR0_LOW     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_RD_LOW      = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_RD_SAMPLE   = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SLOT        = 3'd7;

  // power-on register values, index 0 in the low bits
  localparam logic [CFG_NUM-1:0][CFG_W-1:0] CFG_RESET_VAL = {
    10'd70, 10'd15, 10'd6, 10'd60, 10'd6, 10'd480, 10'd70, 10'd480
  };

  localparam int BITS_W = 4;
  localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RLOW = 3'd1,
    PH_RREL = 3'd2,
    PH_SLOT = 3'd3
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       command_ignored;
  } out_item_t;

endpackage

/* rtl/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire master: reset/presence, byte write and byte read, one tick per beat.
// ----------------------------------------------------------------------------
// Each input beat is one microsecond tick; a nonzero mode also starts a reset,
// a byte write or a byte read when idle (ignored and flagged when busy), and
// that beat already counts as the first tick of the operation. Every input
// beat yields exactly one output beat carrying drive_low, busy, done, presence,
// read data and the ignored flag. Throughput is one beat per clock cycle
// unless the output stalls: a beat lands in the input register, the whole tick
// update (timer increment, limit compares, shift) runs in one pass from there
// into the state and the output register. Output stall backs up into the
// input register and then onto in_stall_o. Timing registers are written over
// the cfg port (always ready) and should only change while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module one_wire_bus_master import owm_pkg::*; #(
  parameter int TIMER_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // tick / command beats
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  // result beats
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  // timing register writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic [CFG_NUM-1:0][TIMER_BITS-1:0] lim;

  assign cfg_ready_o = 1'b1;

  owm_cfg #(.TIMER_BITS(TIMER_BITS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .lim_o      (lim)
  );

  // --- handshake / pipeline control ---
  logic      in_valid_q, out_valid_q;
  in_item_t  in_q;
  out_item_t out_q, out_d;
  logic      adv, fire, in_acc;

  assign adv        = !out_valid_q || !out_stall_i; // result slot free this cycle
  assign fire       = in_valid_q && adv;            // tick is applied to state
  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) in_valid_q <= 1'b1;
      else if (fire) in_valid_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
    if (fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --- bus state ---
  phase_e              phase_q, phase_d;
  logic [TIMER_BITS-1:0] tmr_q, tmr_d;
  logic [BITS_W-1:0]   bits_q, bits_d;
  logic [7:0]          shift_q, shift_d;
  logic                rd_q, rd_d;
  logic                pres_q, pres_d;
  logic [7:0]          rdata_q, rdata_d;
  logic                drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tmr_q   <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      rd_q    <= 1'b0;
      pres_q  <= 1'b0;
      rdata_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      tmr_q   <= tmr_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      rd_q    <= rd_d;
      pres_q  <= pres_d;
      rdata_q <= rdata_d;
    end
  end

  // --- one tick ---
  always_comb begin
    logic                  ignored, done;
    logic [TIMER_BITS-1:0] c, lowlen;
    phase_d = phase_q;
    tmr_d   = tmr_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    rd_d    = rd_q;
    pres_d  = pres_q;
    rdata_d = rdata_q;
    drive_d = 1'b0;
    ignored = 1'b0;
    done    = 1'b0;
    lowlen  = '0;

    // start command; busy means ignore but keep ticking
    if (mode_e'(in_q.mode) != MODE_TICK) begin
      if (phase_q != PH_IDLE) begin
        ignored = 1'b1;
      end else begin
        tmr_d  = '0;
        bits_d = '0;
        if (mode_e'(in_q.mode) == MODE_RESET) begin
          phase_d = PH_RLOW;
          pres_d  = 1'b0;
        end else begin
          phase_d = PH_SLOT;
          rd_d    = (mode_e'(in_q.mode) == MODE_READ);
          shift_d = (mode_e'(in_q.mode) == MODE_WRITE) ? in_q.data_byte : 8'h00;
        end
      end
    end

    // saturating tick count within the segment
    c = (tmr_d == TMAX) ? TMAX : tmr_d + TIMER_BITS'(1);

    case (phase_d)
      PH_RLOW: begin
        drive_d = 1'b1;
        if (c >= lim[CFG_RESET_LOW]) begin
          phase_d = PH_RREL;
          tmr_d   = '0;
        end else begin
          tmr_d = c;
        end
      end
      PH_RREL: begin
        if (c == lim[CFG_PRES_SAMPLE]) pres_d = !in_q.line_level;
        if (c >= lim[CFG_RESET_REL]) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
          tmr_d   = '0;
        end else begin
          tmr_d = c;
        end
      end
      PH_SLOT: begin
        if (rd_d) begin
          lowlen = lim[CFG_RD_LOW];
          if (c == TIMER_BITS'(1)) shift_d = {1'b0, shift_d[7:1]};
          if (c == lim[CFG_RD_SAMPLE] && in_q.line_level) shift_d[7] = 1'b1;
        end else begin
          lowlen = shift_d[0] ? lim[CFG_WR1_LOW] : lim[CFG_WR0_LOW];
        end
        drive_d = (c <= lowlen);
        if (c >= lim[CFG_SLOT]) begin
          tmr_d  = '0;
          bits_d = bits_d + BITS_W'(1);
          if (!rd_d) shift_d = {1'b0, shift_d[7:1]};
          if (bits_d >= BITS_PER_BYTE) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            if (rd_d) rdata_d = shift_d;
          end
        end else begin
          tmr_d = c;
        end
      end
      default: ;
    endcase

    out_d.drive_low       = drive_d;
    out_d.busy_res        = (phase_d != PH_IDLE);
    out_d.done_res        = done;
    out_d.presence        = pres_d;
    out_d.read_data       = rdata_d;
    out_d.command_ignored = ignored;
  end

  // --- checks ---
  `ASSERT_PROP(a_idle_timer_clear, clk_i, rst_ni, (phase_q == PH_IDLE) |-> (tmr_q == '0))
  `ASSERT_NEVER(a_bits_range, clk_i, rst_ni, bits_q > BITS_PER_BYTE)
  `ASSERT_PROP(a_fire_gives_beat, clk_i, rst_ni, fire |=> out_valid_q)
  `ASSERT_PROP(a_done_idle, clk_i, rst_ni, (out_valid_q && out_q.done_res) |-> !out_q.busy_res)

endmodule

/* rtl/owm_cfg.sv */
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register file; presents each limit clamped to 1..timer max.
// ----------------------------------------------------------------------------
module owm_cfg import owm_pkg::*; #(
  parameter int TIMER_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [CFG_IW-1:0]                   wr_index_i,
  input  logic [CFG_W-1:0]                    wr_data_i,
  output logic [CFG_NUM-1:0][TIMER_BITS-1:0]  lim_o
);

  localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [LW-1:0] TMAX_L = LW'((64'd1 << TIMER_BITS) - 64'd1);

  logic [CFG_NUM-1:0][CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET_VAL;
    end else if (wr_en_i) begin
      cfg_q[wr_index_i] <= wr_data_i;
    end
  end

  always_comb begin
    logic [LW-1:0] v;
    v = '0;
    for (int i = 0; i < CFG_NUM; i++) begin
      v = LW'(cfg_q[i]);
      if (v == '0) v = LW'(1);
      if (v > TMAX_L) v = TMAX_L;
      lim_o[i] = v[TIMER_BITS-1:0];
    end
  end

endmodule
